// ===== hw/rtl/batac_pkg.sv =====
// Shared constants, codes and interface types for the bond-axis torque accumulator.
package batac_pkg;

  localparam int CHUNK_W     = 32;
  localparam int A_CHUNKS    = 3;
  localparam int B_CHUNKS    = 2;
  localparam int MUL_A_W     = CHUNK_W * A_CHUNKS;
  localparam int MUL_B_W     = CHUNK_W * B_CHUNKS;
  localparam int PROD_W      = 128;
  localparam int MUL_STEPS   = A_CHUNKS * B_CHUNKS;
  localparam int STEP_W      = 3;
  localparam int FORCE_W     = 32;
  localparam int RECIP_W     = 32;
  localparam int RECIP_SHIFT = 24;
  localparam int SCALED_W    = PROD_W - RECIP_SHIFT;
  localparam int TORQUE_W    = 64;
  localparam int CROSS_W     = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CROSS_W-1:0] CROSS_MIN = CROSS_W'(1) << (CROSS_W - 1);
  localparam logic [CROSS_W-1:0] CROSS_MAX = ~CROSS_MIN;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_X   = 3'd0,
    REG_AXIS_Y   = 3'd1,
    REG_AXIS_Z   = 3'd2,
    REG_PIVOT_X  = 3'd3,
    REG_PIVOT_Y  = 3'd4,
    REG_PIVOT_Z  = 3'd5,
    REG_RECIP    = 3'd6,
    REG_NEGATE   = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_AY_DZ = 4'd0,
    OP_AZ_DY = 4'd1,
    OP_AZ_DX = 4'd2,
    OP_AX_DZ = 4'd3,
    OP_AX_DY = 4'd4,
    OP_AY_DX = 4'd5,
    OP_CX_FX = 4'd6,
    OP_CY_FY = 4'd7,
    OP_CZ_FZ = 4'd8,
    OP_SCALE = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_ISSUE = 3'd1,
    ST_WAIT  = 3'd2,
    ST_ACCUM = 3'd3,
    ST_EMIT  = 3'd4
  } back_state_t;

  typedef struct packed {
    logic               start;
    logic               neg;
    logic [MUL_A_W-1:0] a_mag;
    logic [MUL_B_W-1:0] b_mag;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

endpackage

// ===== hw/rtl/batac_front.sv =====
// Front end: accepts atom beats, forms offsets from the pivot and queues them.
module batac_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_WIDTH-1:0]   in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]   in_pos_y,
  input  logic signed [COORD_WIDTH-1:0]   in_pos_z,
  input  logic signed [batac_pkg::FORCE_W-1:0] in_force_x,
  input  logic signed [batac_pkg::FORCE_W-1:0] in_force_y,
  input  logic signed [batac_pkg::FORCE_W-1:0] in_force_z,
  input  logic                            in_last_atom,
  input  logic signed [COORD_WIDTH-1:0]   pivot_x,
  input  logic signed [COORD_WIDTH-1:0]   pivot_y,
  input  logic signed [COORD_WIDTH-1:0]   pivot_z,
  output logic                            q_valid,
  input  logic                            q_pop,
  output logic signed [COORD_WIDTH:0]     q_dx,
  output logic signed [COORD_WIDTH:0]     q_dy,
  output logic signed [COORD_WIDTH:0]     q_dz,
  output logic signed [batac_pkg::FORCE_W-1:0] q_fx,
  output logic signed [batac_pkg::FORCE_W-1:0] q_fy,
  output logic signed [batac_pkg::FORCE_W-1:0] q_fz,
  output logic                            q_last
);
  import batac_pkg::*;

  localparam int D_W     = COORD_WIDTH + 1;
  localparam int ENTRY_W = 3 * D_W + 3 * FORCE_W + 1;
  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

  logic [ENTRY_W-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               push;
  logic               pop;
  logic signed [D_W-1:0] dx, dy, dz;
  logic [ENTRY_W-1:0] wr_entry;
  logic [ENTRY_W-1:0] rd_entry;

  assign in_stall = (count_r == CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;

  assign dx = D_W'(in_pos_x) - D_W'(pivot_x);
  assign dy = D_W'(in_pos_y) - D_W'(pivot_y);
  assign dz = D_W'(in_pos_z) - D_W'(pivot_z);

  assign wr_entry = {dx, dy, dz, in_force_x, in_force_y, in_force_z, in_last_atom};
  assign rd_entry = mem_r[rd_ptr_r];
  assign {q_dx, q_dy, q_dz, q_fx, q_fy, q_fz, q_last} = rd_entry;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/batac_mul.sv =====
// Shared multiplier: magnitude product from 32x32 partial products, sign applied at the end.
module batac_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  batac_pkg::mul_req_t req,
  output batac_pkg::mul_rsp_t rsp
);
  import batac_pkg::*;

  logic [MUL_A_W-1:0]   a_r;
  logic [MUL_B_W-1:0]   b_r;
  logic                 neg_r;
  logic                 busy_r;
  logic                 pp_v_r;
  logic                 done_r;
  logic [STEP_W-1:0]    step_r;
  logic [1:0]           pp_sh_r;
  logic [2*CHUNK_W-1:0] pp_r;
  logic [PROD_W-1:0]    acc_r;
  logic [PROD_W-1:0]    res_r;

  logic                 b_sel;
  logic [1:0]           a_sel;
  logic [CHUNK_W-1:0]   a_chunk;
  logic [CHUNK_W-1:0]   b_chunk;
  logic [PROD_W-1:0]    pp_ext;
  logic                 mul_step;
  logic                 last_step;

  assign mul_step  = (step_r < STEP_W'(MUL_STEPS));
  assign last_step = (step_r == STEP_W'(MUL_STEPS + 1));

  always_comb begin
    b_sel = (step_r >= STEP_W'(A_CHUNKS));
    a_sel = b_sel ? 2'(step_r - STEP_W'(A_CHUNKS)) : 2'(step_r);
    unique case (a_sel)
      2'd0:    a_chunk = a_r[CHUNK_W-1:0];
      2'd1:    a_chunk = a_r[2*CHUNK_W-1:CHUNK_W];
      2'd2:    a_chunk = a_r[3*CHUNK_W-1:2*CHUNK_W];
      default: a_chunk = '0;
    endcase
    b_chunk = b_sel ? b_r[2*CHUNK_W-1:CHUNK_W] : b_r[CHUNK_W-1:0];
    unique case (pp_sh_r)
      2'd0:    pp_ext = PROD_W'(pp_r);
      2'd1:    pp_ext = PROD_W'(pp_r) << CHUNK_W;
      2'd2:    pp_ext = PROD_W'(pp_r) << (2 * CHUNK_W);
      default: pp_ext = PROD_W'(pp_r) << (3 * CHUNK_W);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pp_v_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        pp_v_r <= 1'b0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        pp_v_r <= mul_step;
        if (last_step) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a_mag;
      b_r   <= req.b_mag;
      neg_r <= req.neg;
      acc_r <= '0;
    end else if (busy_r) begin
      if (mul_step) begin
        pp_r    <= (2*CHUNK_W)'(a_chunk) * (2*CHUNK_W)'(b_chunk);
        pp_sh_r <= a_sel + 2'(b_sel);
      end
      if (pp_v_r) begin
        acc_r <= acc_r + pp_ext;
      end
      if (last_step) begin
        res_r <= neg_r ? (PROD_W'(0) - acc_r) : acc_r;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = res_r;

endmodule

// ===== hw/rtl/batac_back.sv =====
// Back end: sequences cross, dot and scale products and runs the saturating accumulator.
module batac_back #(
  parameter int COORD_WIDTH = 32,
  parameter int ACC_WIDTH   = 64,
  parameter int FRAC_BITS   = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic signed [COORD_WIDTH-1:0]   axis_x,
  input  logic signed [COORD_WIDTH-1:0]   axis_y,
  input  logic signed [COORD_WIDTH-1:0]   axis_z,
  input  logic [batac_pkg::RECIP_W-1:0]   recip_len,
  input  logic                            negate_mode,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  logic signed [COORD_WIDTH:0]     q_dx,
  input  logic signed [COORD_WIDTH:0]     q_dy,
  input  logic signed [COORD_WIDTH:0]     q_dz,
  input  logic signed [batac_pkg::FORCE_W-1:0] q_fx,
  input  logic signed [batac_pkg::FORCE_W-1:0] q_fy,
  input  logic signed [batac_pkg::FORCE_W-1:0] q_fz,
  input  logic                            q_last,
  output batac_pkg::mul_req_t             mul_req,
  input  batac_pkg::mul_rsp_t             mul_rsp,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [batac_pkg::TORQUE_W-1:0] out_torque_sum,
  output logic                            out_saturated
);
  import batac_pkg::*;

  localparam logic [SCALED_W-1:0]  LIM_NEG = SCALED_W'(1) << (ACC_WIDTH - 1);
  localparam logic [SCALED_W-1:0]  LIM_POS = LIM_NEG - SCALED_W'(1);
  localparam logic [ACC_WIDTH-1:0] ACC_MIN = ACC_WIDTH'(1) << (ACC_WIDTH - 1);
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = ~ACC_MIN;

  back_state_t state_r, state_nxt;
  op_t         op_r;
  logic        mul_start;
  logic        out_free;

  logic signed [PROD_W-1:0]    hold_r;
  logic signed [CROSS_W-1:0]   cx_r, cy_r, cz_r;
  logic signed [PROD_W-1:0]    t_r;
  logic [ACC_WIDTH-1:0]        m_r;
  logic                        mneg_r;
  logic signed [ACC_WIDTH-1:0] acc_r;
  logic                        clip_r;
  logic                        out_valid_r;
  logic signed [TORQUE_W-1:0]  out_torque_sum_r;
  logic                        out_saturated_r;

  logic signed [CROSS_W-1:0]   sa, sb;
  logic [CROSS_W-1:0]          sa_mag, sb_mag;
  logic                        t_neg;
  logic [PROD_W-1:0]           t_abs;
  logic                        t_ovf;
  logic [MUL_A_W-1:0]          t_clamp;
  logic signed [PROD_W-1:0]    prod_s;
  logic signed [PROD_W-1:0]    prod_sh;
  logic signed [PROD_W-1:0]    diff;
  logic                        cross_ovf;
  logic [CROSS_W-1:0]          cross_val;
  logic [SCALED_W-1:0]         scaled;
  logic [SCALED_W-1:0]         lim;
  logic                        m_ovf;
  logic [ACC_WIDTH-1:0]        m_val;
  logic signed [ACC_WIDTH+1:0] acc_ext, m_ext, acc_sum;
  logic                        acc_ovf;
  logic [ACC_WIDTH-1:0]        acc_val;
  logic                        rsp_done;
  logic                        odd_cross;

  assign out_free = !out_valid_r || !out_stall;
  assign rsp_done = (state_r == ST_WAIT) && mul_rsp.done;

  // operand select
  always_comb begin
    unique case (op_r)
      OP_AY_DZ: begin sa = CROSS_W'(q_dz); sb = CROSS_W'(axis_y); end
      OP_AZ_DY: begin sa = CROSS_W'(q_dy); sb = CROSS_W'(axis_z); end
      OP_AZ_DX: begin sa = CROSS_W'(q_dx); sb = CROSS_W'(axis_z); end
      OP_AX_DZ: begin sa = CROSS_W'(q_dz); sb = CROSS_W'(axis_x); end
      OP_AX_DY: begin sa = CROSS_W'(q_dy); sb = CROSS_W'(axis_x); end
      OP_AY_DX: begin sa = CROSS_W'(q_dx); sb = CROSS_W'(axis_y); end
      OP_CX_FX: begin sa = cx_r; sb = CROSS_W'(q_fx); end
      OP_CY_FY: begin sa = cy_r; sb = CROSS_W'(q_fy); end
      OP_CZ_FZ: begin sa = cz_r; sb = CROSS_W'(q_fz); end
      default:  begin sa = '0; sb = '0; end
    endcase
    sa_mag = sa[CROSS_W-1] ? (CROSS_W'(0) - CROSS_W'(sa)) : CROSS_W'(sa);
    sb_mag = sb[CROSS_W-1] ? (CROSS_W'(0) - CROSS_W'(sb)) : CROSS_W'(sb);
  end

  assign t_neg   = t_r[PROD_W-1];
  assign t_abs   = t_neg ? (PROD_W'(0) - PROD_W'(t_r)) : PROD_W'(t_r);
  assign t_ovf   = (t_abs[PROD_W-1:MUL_A_W] != '0);
  assign t_clamp = t_ovf ? '1 : t_abs[MUL_A_W-1:0];

  assign mul_req = '{
    start: mul_start,
    neg:   (op_r == OP_SCALE) ? 1'b0 : (sa[CROSS_W-1] ^ sb[CROSS_W-1]),
    a_mag: (op_r == OP_SCALE) ? t_clamp : MUL_A_W'(sa_mag),
    b_mag: (op_r == OP_SCALE) ? MUL_B_W'(recip_len) : sb_mag
  };

  // product post-processing
  always_comb begin
    prod_s    = mul_rsp.prod;
    prod_sh   = prod_s >>> FRAC_BITS;
    diff      = hold_r - prod_sh;
    cross_ovf = !((diff[PROD_W-1:CROSS_W-1] == '0) || (diff[PROD_W-1:CROSS_W-1] == '1));
    cross_val = cross_ovf ? (diff[PROD_W-1] ? CROSS_MIN : CROSS_MAX) : diff[CROSS_W-1:0];
    odd_cross = (op_r == OP_AZ_DY) || (op_r == OP_AX_DZ) || (op_r == OP_AY_DX);
    scaled    = mul_rsp.prod[PROD_W-1:RECIP_SHIFT];
    lim       = mneg_r ? LIM_NEG : LIM_POS;
    m_ovf     = (scaled > lim);
    m_val     = ACC_WIDTH'(m_ovf ? lim : scaled);
  end

  // saturating accumulate
  always_comb begin
    acc_ext = (ACC_WIDTH+2)'(acc_r);
    m_ext   = {2'b00, m_r};
    acc_sum = mneg_r ? (acc_ext - m_ext) : (acc_ext + m_ext);
    acc_ovf = (acc_sum[ACC_WIDTH+1:ACC_WIDTH-1] != 3'b000) &&
              (acc_sum[ACC_WIDTH+1:ACC_WIDTH-1] != 3'b111);
    acc_val = acc_ovf ? (mneg_r ? ACC_MIN : ACC_MAX) : acc_sum[ACC_WIDTH-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    mul_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        mul_start = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_rsp.done) begin
          state_nxt = (op_r == OP_SCALE) ? ST_ACCUM : ST_ISSUE;
        end
      end
      ST_ACCUM: begin
        q_pop     = 1'b1;
        state_nxt = q_last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_AY_DZ;
      acc_r       <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) begin
        op_r <= OP_AY_DZ;
      end else if (rsp_done && op_r != OP_SCALE) begin
        op_r <= op_t'(op_r + 4'd1);
      end
      if ((state_r == ST_ISSUE && op_r == OP_SCALE && t_ovf) ||
          (rsp_done && odd_cross && cross_ovf) ||
          (rsp_done && op_r == OP_SCALE && m_ovf) ||
          (state_r == ST_ACCUM && acc_ovf)) begin
        clip_r <= 1'b1;
      end
      if (state_r == ST_ACCUM) begin
        acc_r <= acc_val;
      end
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
        acc_r       <= '0;
        clip_r      <= 1'b0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ISSUE && op_r == OP_SCALE) begin
      mneg_r <= t_neg ^ negate_mode;
    end
    if (rsp_done) begin
      unique case (op_r)
        OP_AY_DZ, OP_AZ_DX, OP_AX_DY: hold_r <= prod_sh;
        OP_AZ_DY: cx_r <= cross_val;
        OP_AX_DZ: cy_r <= cross_val;
        OP_AY_DX: cz_r <= cross_val;
        OP_CX_FX: t_r  <= prod_s;
        OP_CY_FY, OP_CZ_FZ: t_r <= t_r + prod_s;
        OP_SCALE: m_r  <= m_val;
        default: ;
      endcase
    end
    if (state_r == ST_EMIT && out_free) begin
      out_torque_sum_r <= TORQUE_W'(acc_r);
      out_saturated_r  <= clip_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_torque_sum = out_torque_sum_r;
  assign out_saturated  = out_saturated_r;

endmodule

// ===== hw/rtl/bond_axis_torque_accumulator.sv =====
// Top level of the bond-axis torque accumulator: configuration registers and unit hookup.
// Each atom needs ten products; they go through one 32x32 multiplier
//   at six partial products each.
// A two-beat input queue keeps accepting, until it is full, while the back end works or a result waits.
// Synchronous reset clears configuration, accumulator, saturation flag, queue and output.
module bond_axis_torque_accumulator #(
  parameter int COORD_WIDTH = 32,
  parameter int ACC_WIDTH   = 64,
  parameter int FRAC_BITS   = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_write,
  input  logic [batac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [COORD_WIDTH-1:0]        in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]        in_pos_y,
  input  logic signed [COORD_WIDTH-1:0]        in_pos_z,
  input  logic signed [batac_pkg::FORCE_W-1:0] in_force_x,
  input  logic signed [batac_pkg::FORCE_W-1:0] in_force_y,
  input  logic signed [batac_pkg::FORCE_W-1:0] in_force_z,
  input  logic                                 in_last_atom,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [batac_pkg::TORQUE_W-1:0] out_torque_sum,
  output logic                                 out_saturated
);
  import batac_pkg::*;

  logic signed [COORD_WIDTH-1:0] axis_x_r, axis_y_r, axis_z_r;
  logic signed [COORD_WIDTH-1:0] pivot_x_r, pivot_y_r, pivot_z_r;
  logic [RECIP_W-1:0]            recip_len_r;
  logic                          negate_mode_r;

  logic                          q_valid;
  logic                          q_pop;
  logic signed [COORD_WIDTH:0]   q_dx, q_dy, q_dz;
  logic signed [FORCE_W-1:0]     q_fx, q_fy, q_fz;
  logic                          q_last;
  mul_req_t                      mul_req;
  mul_rsp_t                      mul_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_x_r      <= '0;
      axis_y_r      <= '0;
      axis_z_r      <= '0;
      pivot_x_r     <= '0;
      pivot_y_r     <= '0;
      pivot_z_r     <= '0;
      recip_len_r   <= '0;
      negate_mode_r <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AXIS_X:  axis_x_r      <= cfg_data[COORD_WIDTH-1:0];
        REG_AXIS_Y:  axis_y_r      <= cfg_data[COORD_WIDTH-1:0];
        REG_AXIS_Z:  axis_z_r      <= cfg_data[COORD_WIDTH-1:0];
        REG_PIVOT_X: pivot_x_r     <= cfg_data[COORD_WIDTH-1:0];
        REG_PIVOT_Y: pivot_y_r     <= cfg_data[COORD_WIDTH-1:0];
        REG_PIVOT_Z: pivot_z_r     <= cfg_data[COORD_WIDTH-1:0];
        REG_RECIP:   recip_len_r   <= cfg_data[RECIP_W-1:0];
        REG_NEGATE:  negate_mode_r <= cfg_data[0];
      endcase
    end
  end

  batac_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_pos_z     (in_pos_z),
    .in_force_x   (in_force_x),
    .in_force_y   (in_force_y),
    .in_force_z   (in_force_z),
    .in_last_atom (in_last_atom),
    .pivot_x      (pivot_x_r),
    .pivot_y      (pivot_y_r),
    .pivot_z      (pivot_z_r),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_dx         (q_dx),
    .q_dy         (q_dy),
    .q_dz         (q_dz),
    .q_fx         (q_fx),
    .q_fy         (q_fy),
    .q_fz         (q_fz),
    .q_last       (q_last)
  );

  batac_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  batac_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .ACC_WIDTH   (ACC_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .axis_x         (axis_x_r),
    .axis_y         (axis_y_r),
    .axis_z         (axis_z_r),
    .recip_len      (recip_len_r),
    .negate_mode    (negate_mode_r),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_dx           (q_dx),
    .q_dy           (q_dy),
    .q_dz           (q_dz),
    .q_fx           (q_fx),
    .q_fy           (q_fy),
    .q_fz           (q_fz),
    .q_last         (q_last),
    .mul_req        (mul_req),
    .mul_rsp        (mul_rsp),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_torque_sum (out_torque_sum),
    .out_saturated  (out_saturated)
  );

endmodule
